### rtl/yuv422_to_rgb888_macros.svh
// ----------------------------------------------------------------------------
// yuv422_to_rgb888 assertion macros
// shared assertion forms for the conversion block checkers
// ----------------------------------------------------------------------------
`ifndef YUV422_TO_RGB888_MACROS_SVH
`define YUV422_TO_RGB888_MACROS_SVH

// checked only outside reset
`define Y2R_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define Y2R_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// types, constants and saturation helper for the yuv 4:2:2 to rgb888 block
// ----------------------------------------------------------------------------
package y2r_pkg;

   localparam int PIX_W  = 8;
   localparam int PROD_W = 17;
   localparam int SUM_W  = 18;

   localparam logic signed [PROD_W-1:0] CV_RED   = 17'sd358;
   localparam logic signed [PROD_W-1:0] CV_GREEN = 17'sd182;
   localparam logic signed [PROD_W-1:0] CU_GREEN = 17'sd88;
   localparam logic signed [PROD_W-1:0] CU_BLUE  = 17'sd454;
   localparam logic signed [SUM_W-1:0]  SAT_MAX  = 18'sd65280;

   typedef struct packed {
      logic [PIX_W-1:0] luma_first;
      logic [PIX_W-1:0] chroma_u;
      logic [PIX_W-1:0] luma_second;
      logic [PIX_W-1:0] chroma_v;
   } y2r_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_first;
      logic [PIX_W-1:0] green_first;
      logic [PIX_W-1:0] blue_first;
      logic [PIX_W-1:0] red_second;
      logic [PIX_W-1:0] green_second;
      logic [PIX_W-1:0] blue_second;
   } y2r_rsp_type;

   typedef struct packed {
      logic [PIX_W-1:0]         luma_first;
      logic [PIX_W-1:0]         luma_second;
      logic signed [PROD_W-1:0] red_v;
      logic signed [PROD_W-1:0] green_u;
      logic signed [PROD_W-1:0] green_v;
      logic signed [PROD_W-1:0] blue_u;
   } y2r_prod_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] red_first;
      logic signed [SUM_W-1:0] green_first;
      logic signed [SUM_W-1:0] blue_first;
      logic signed [SUM_W-1:0] red_second;
      logic signed [SUM_W-1:0] green_second;
      logic signed [SUM_W-1:0] blue_second;
   } y2r_sum_type;

   function automatic logic [PIX_W-1:0] y2r_sat(input logic signed [SUM_W-1:0] sum);
      logic [PIX_W-1:0] res;
      if (sum < 0) begin
         res = '0;
      end else if (sum > SAT_MAX) begin
         res = '1;
      end else begin
         res = sum[15:8];
      end
      return res;
   endfunction

endpackage

### rtl/y2r_mult.sv
// ----------------------------------------------------------------------------
// y2r_mult
// first stage: removes the chroma offset and forms the four chroma products
// ----------------------------------------------------------------------------
module y2r_mult
   import y2r_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  y2r_req_type  in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output y2r_prod_type out_item
);

   logic                     valid_ff;
   logic                     valid_in;
   y2r_prod_type             item_ff;
   y2r_prod_type             item_in;
   y2r_prod_type             prod;
   logic signed [PROD_W-1:0] u_wide;
   logic signed [PROD_W-1:0] v_wide;

   // chroma minus 128 is the byte with its top bit flipped, read as signed
   assign u_wide = PROD_W'($signed({~in_item.chroma_u[PIX_W-1], in_item.chroma_u[PIX_W-2:0]}));
   assign v_wide = PROD_W'($signed({~in_item.chroma_v[PIX_W-1], in_item.chroma_v[PIX_W-2:0]}));

   always_comb begin
      prod.luma_first  = in_item.luma_first;
      prod.luma_second = in_item.luma_second;
      prod.red_v       = v_wide * CV_RED;
      prod.green_u     = u_wide * CU_GREEN;
      prod.green_v     = v_wide * CV_GREEN;
      prod.blue_u      = u_wide * CU_BLUE;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign item_in  = (in_ready && in_valid) ? prod : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### rtl/y2r_sum.sv
// ----------------------------------------------------------------------------
// y2r_sum
// second stage: adds scaled luma and chroma products for all six channels
// ----------------------------------------------------------------------------
module y2r_sum
   import y2r_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  y2r_prod_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output y2r_sum_type  out_item
);

   logic                    valid_ff;
   logic                    valid_in;
   y2r_sum_type             item_ff;
   y2r_sum_type             item_in;
   y2r_sum_type             sum;
   logic signed [SUM_W-1:0] y_first;
   logic signed [SUM_W-1:0] y_second;
   logic signed [SUM_W-1:0] red_c;
   logic signed [SUM_W-1:0] green_c;
   logic signed [SUM_W-1:0] blue_c;

   assign y_first  = $signed({2'b00, in_item.luma_first, 8'h00});
   assign y_second = $signed({2'b00, in_item.luma_second, 8'h00});

   // chroma terms shared by both pixels
   assign red_c   = SUM_W'(in_item.red_v);
   assign green_c = -SUM_W'(in_item.green_u) - SUM_W'(in_item.green_v);
   assign blue_c  = SUM_W'(in_item.blue_u);

   always_comb begin
      sum.red_first    = y_first + red_c;
      sum.green_first  = y_first + green_c;
      sum.blue_first   = y_first + blue_c;
      sum.red_second   = y_second + red_c;
      sum.green_second = y_second + green_c;
      sum.blue_second  = y_second + blue_c;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign item_in  = (in_ready && in_valid) ? sum : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### rtl/y2r_clamp.sv
// ----------------------------------------------------------------------------
// y2r_clamp
// last stage: saturates each channel to 0..0xff00, keeps the high byte
// ----------------------------------------------------------------------------
module y2r_clamp
   import y2r_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  y2r_sum_type in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output y2r_rsp_type out_item
);

   logic        valid_ff;
   logic        valid_in;
   y2r_rsp_type item_ff;
   y2r_rsp_type item_in;
   y2r_rsp_type pix;

   always_comb begin
      pix.red_first    = y2r_sat(in_item.red_first);
      pix.green_first  = y2r_sat(in_item.green_first);
      pix.blue_first   = y2r_sat(in_item.blue_first);
      pix.red_second   = y2r_sat(in_item.red_second);
      pix.green_second = y2r_sat(in_item.green_second);
      pix.blue_second  = y2r_sat(in_item.blue_second);
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign item_in  = (in_ready && in_valid) ? pix : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### rtl/yuv422_to_rgb888.sv
// ----------------------------------------------------------------------------
// yuv422_to_rgb888
// converts one packed 4:2:2 word into two rgb888 pixels
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  y2r_req_type (two lumas, u, v)
//   rsp      out        rsp_valid / rsp_ready  y2r_rsp_type (two rgb pixels)
//
// one item per cycle while rsp is not stalled; registered stages: products, sums, saturation
// each stage holds one item; ready runs back from rsp_ready through the stages
// a stall at rsp holds every full stage, empty stages keep filling
// synchronous reset empties the pipeline
// ----------------------------------------------------------------------------
module yuv422_to_rgb888
   import y2r_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  y2r_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output y2r_rsp_type rsp_item
);

   logic         prod_valid;
   logic         prod_ready;
   y2r_prod_type prod_item;
   logic         sum_valid;
   logic         sum_ready;
   y2r_sum_type  sum_item;

   y2r_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_item  (prod_item)
   );

   y2r_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_item   (prod_item),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_item  (sum_item)
   );

   y2r_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_item   (sum_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

endmodule

### rtl/y2r_checker.sv
// ----------------------------------------------------------------------------
// y2r_checker
// port-level checks on the conversion pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "yuv422_to_rgb888_macros.svh"

module y2r_checker
   import y2r_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input y2r_req_type req_item,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input y2r_rsp_type rsp_item
);

   logic req_fire;
   logic req_stall;
   logic rsp_stall;

   assign req_fire  = req_valid && req_ready;
   assign req_stall = req_valid && !req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // a waiting item holds
   `Y2R_ASSERT_CLK(a_req_hold, req_stall |=> req_valid && $stable(req_item), "req item moved")

   // a stalled result holds
   `Y2R_ASSERT_CLK(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_item), "rsp item moved")

   // reset empties the pipeline
   `Y2R_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "rsp valid right after reset")

   // an open output means every stage can take an item
   `Y2R_ASSERT_CLK(a_ready_chain, rsp_ready |-> req_ready, "req not ready while rsp ready")

   // an item with a free path passes the product, sum and saturation registers and comes out
   `Y2R_ASSERT_CLK(a_latency, req_fire ##1 rsp_ready [*2] |=> rsp_valid, "item missing at output")

endmodule

bind yuv422_to_rgb888 y2r_checker u_checker (.*);
